FILE: hdl/linear_interp_resampler_defines.svh
// Assertion macros used by the resampler checker.
`ifndef LINEAR_INTERP_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_RESAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define LIR_ASSERT_NOW(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LIR_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lir_pkg.sv
// Types and constants of the linear interpolation resampler.
`default_nettype none
package lir_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned STEP_W    = FRAC_BITS + 8;   // Q8.FRAC step
  localparam int unsigned ACC_W     = FRAC_BITS + 9;   // stored phase accumulator
  localparam int unsigned POS_W     = ACC_W + 1;       // working position, room for +step
  localparam int unsigned ONE_POS   = 1 << FRAC_BITS;
  localparam int unsigned MIN_STEP  = ONE_POS >> 4;
  localparam int unsigned MAX_OUT   = 32;
  localparam int unsigned CNT_W     = $clog2(MAX_OUT + 1);
  localparam int unsigned PROD_W    = SAMPLE_W + 1 + FRAC_BITS + 1;
  localparam int unsigned SUM_W     = PROD_W;
  localparam int unsigned QDEPTH    = 2;               // power of two
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);

  localparam logic [STEP_W-1:0] STEP_ONE = STEP_W'(ONE_POS);
  localparam logic [STEP_W-1:0] STEP_MIN = STEP_W'(MIN_STEP);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       stream_last;
  } lir_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       run_end;
    logic                       stream_end;
  } lir_out_t;

  // One classified input, as passed from the front end to the back end.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] prev;
    logic signed [SAMPLE_W-1:0] cur;
    logic                       have_prev;
    logic                       last;
    logic [STEP_W-1:0]          step;
  } lir_job_t;

endpackage
`default_nettype wire

FILE: hdl/linear_interp_resampler.sv
// Top level of the linear interpolation sample-rate converter.
// Linear interpolation resampler for 16-bit signed audio. Each input sample
// closes the interval from the previous one; every output whose phase falls in
// that interval is the blend prev + (cur - prev) * frac, rounded half up to
// 16 bits. The phase advances per output by the step register (Q8.16, input
// rate over output rate, reset to one); steps below one sixteenth are used as
// one sixteenth, so one input gives at most 32 outputs. On an input marked
// stream_last, outputs at or past that sample hold it while phase + step stays
// within one, the last of them carries stream_end, and the phase and previous
// sample return to zero. run_end marks the last output of each input.
// The front end takes one transfer per cycle into a two-entry queue while the
// queue is not full. For each input the back-end sequencer steps through its
// outputs and then closes the input (a final input also runs the hold phase
// first); the first sample of a stream is only stored, unless it also ends
// the stream, when it goes straight to the hold phase. A result passes through
// the multiply register and the output register after the sequencer decides
// its flags. The step register may be written only while the block is idle.
`default_nettype none
module linear_interp_resampler (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lir_pkg::STEP_W-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire lir_pkg::lir_in_t            in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output lir_pkg::lir_out_t                out_data_o
);

  // front end to queue
  logic              q_push, q_full;
  lir_pkg::lir_job_t q_job_in;
  // queue to back end
  logic              q_pop, q_empty;
  lir_pkg::lir_job_t q_job_out;

  // Pairs each accepted transfer with the previous sample and snapshots the
  // clamped step, so that the back end never looks at the register itself.
  lir_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_job_o     (q_job_in)
  );

  // Decouples input acceptance from the output-bound sequencer.
  lir_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_job_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .job_o   (q_job_out)
  );

  // Walks the phase across each interval, one output per cycle unless stalled;
  // an output is held back one step so run_end/stream_end can be set at loop end.
  lir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_job_i     (q_job_out),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire

FILE: hdl/lir_front.sv
// Front end: step register, input acceptance and pairing with the previous sample.
`default_nettype none
module lir_front (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [lir_pkg::STEP_W-1:0]   cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire lir_pkg::lir_in_t             in_data_i,
  input  wire logic                         q_full_i,
  output logic                              q_push_o,
  output lir_pkg::lir_job_t                 q_job_o
);

  logic [lir_pkg::STEP_W-1:0]          step_q;
  logic signed [lir_pkg::SAMPLE_W-1:0] prev_q;
  logic                                have_prev_q;
  logic                                accept;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign q_push_o   = accept;

  always_comb begin
    q_job_o.prev      = prev_q;
    q_job_o.cur       = in_data_i.sample_in;
    q_job_o.have_prev = have_prev_q;
    q_job_o.last      = in_data_i.stream_last;
    // tiny steps are raised to one sixteenth
    q_job_o.step      = (step_q < lir_pkg::STEP_MIN) ? lir_pkg::STEP_MIN : step_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= lir_pkg::STEP_ONE;
    end else if (cfg_we_i) begin
      step_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      have_prev_q <= 1'b0;
    end else if (accept) begin
      if (in_data_i.stream_last) begin
        prev_q      <= '0;
        have_prev_q <= 1'b0;
      end else begin
        prev_q      <= in_data_i.sample_in;
        have_prev_q <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lir_queue.sv
// Two-entry job queue between front end and back end.
`default_nettype none
module lir_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_i,
  input  wire lir_pkg::lir_job_t job_i,
  output logic                   full_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output lir_pkg::lir_job_t      job_o
);

  lir_pkg::lir_job_t           entry_q [lir_pkg::QDEPTH];
  logic [lir_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [lir_pkg::QPTR_W:0]    cnt_q, cnt_d;
  logic                        do_push, do_pop;

  assign full_o  = (cnt_q == (lir_pkg::QPTR_W+1)'(lir_pkg::QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/lir_back.sv
// Back end: phase sequencer, blend multiplier, rounding and output register.
`default_nettype none
module lir_back (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_empty_i,
  input  wire lir_pkg::lir_job_t q_job_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output lir_pkg::lir_out_t      out_data_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_INTERP = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  localparam int unsigned FB = lir_pkg::FRAC_BITS;
  localparam int unsigned SW = lir_pkg::SAMPLE_W;
  localparam logic [lir_pkg::POS_W-1:0] POS_ONE = lir_pkg::POS_W'(lir_pkg::ONE_POS);
  localparam logic [lir_pkg::CNT_W-1:0] CNT_MAX = lir_pkg::CNT_W'(lir_pkg::MAX_OUT);
  localparam logic signed [lir_pkg::SUM_W-1:0] HALF =
    lir_pkg::SUM_W'(lir_pkg::ONE_POS >> 1);

  // sequencer
  logic [1:0]                  st_q, st_d;
  logic [lir_pkg::POS_W-1:0]   pos_q, pos_d;
  logic [lir_pkg::CNT_W-1:0]   n_q, n_d;
  logic signed [SW-1:0]        cur_q, prev_q;
  logic                        last_q;
  logic [lir_pkg::STEP_W-1:0]  step_q;
  logic                        load;

  // pending result, flagged once the next move is known
  logic                        pend_v_q, pend_v_d;
  logic signed [SW-1:0]        pend_a_q, pend_a_d, pend_b_q, pend_b_d;
  logic [FB-1:0]               pend_f_q, pend_f_d;
  logic                        push, push_run, push_end;

  // multiply stage and output register
  logic                        a_v_q;
  logic signed [SW-1:0]        a_base_q;
  logic signed [lir_pkg::PROD_W-1:0] a_prod_q;
  logic                        a_run_q, a_end_q;
  logic                        o_v_q;
  lir_pkg::lir_out_t           o_data_q;

  logic                        out_free, a_free;
  logic [lir_pkg::POS_W-1:0]   pos_add, pos_wrap;
  logic                        cap_ok, interp_emit, hold_emit;
  logic signed [SW:0]          diff;
  logic signed [FB:0]          frac_s;
  logic signed [lir_pkg::PROD_W-1:0] prod;
  logic signed [lir_pkg::SUM_W-1:0]  sum;

  assign out_free = !o_v_q || !out_stall_i;
  assign a_free   = !a_v_q || out_free;

  assign pos_add     = pos_q + lir_pkg::POS_W'(step_q);
  assign pos_wrap    = (pos_q >= POS_ONE) ? (pos_q - POS_ONE) : '0;
  assign cap_ok      = (n_q < CNT_MAX);
  assign interp_emit = (pos_q < POS_ONE) && cap_ok;
  assign hold_emit   = (pos_add <= POS_ONE) && cap_ok;

  always_comb begin
    st_d     = st_q;
    pos_d    = pos_q;
    n_d      = n_q;
    pend_v_d = pend_v_q;
    pend_a_d = pend_a_q;
    pend_b_d = pend_b_q;
    pend_f_d = pend_f_q;
    push     = 1'b0;
    push_run = 1'b0;
    push_end = 1'b0;
    load     = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        load = !q_empty_i;
      end
      ST_INTERP: begin
        if (a_free) begin
          if (interp_emit) begin
            push     = pend_v_q;
            pend_v_d = 1'b1;
            pend_a_d = prev_q;
            pend_b_d = cur_q;
            pend_f_d = pos_q[FB-1:0];
            pos_d    = pos_add;
            n_d      = n_q + 1'b1;
          end else begin
            pos_d = {1'b0, pos_wrap[lir_pkg::ACC_W-1:0]};
            if (last_q) begin
              st_d = ST_HOLD;
            end else begin
              push     = pend_v_q;
              push_run = 1'b1;
              pend_v_d = 1'b0;
              st_d     = ST_IDLE;
              load     = !q_empty_i;
            end
          end
        end
      end
      ST_HOLD: begin
        if (a_free) begin
          if (hold_emit) begin
            push     = pend_v_q;
            pend_v_d = 1'b1;
            pend_a_d = cur_q;
            pend_b_d = cur_q;
            pend_f_d = '0;
            pos_d    = pos_add;
            n_d      = n_q + 1'b1;
          end else begin
            // end of stream: accumulator restarts
            pos_d    = '0;
            push     = pend_v_q;
            push_run = 1'b1;
            push_end = 1'b1;
            pend_v_d = 1'b0;
            st_d     = ST_IDLE;
            load     = !q_empty_i;
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
    if (load) begin
      n_d = '0;
      priority if (q_job_i.have_prev) begin
        st_d = ST_INTERP;
      end else if (q_job_i.last) begin
        st_d = ST_HOLD;
      end else begin
        st_d = ST_IDLE;
      end
    end
  end

  assign q_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      pos_q    <= '0;
      n_q      <= '0;
      pend_v_q <= 1'b0;
      a_v_q    <= 1'b0;
      o_v_q    <= 1'b0;
    end else begin
      st_q     <= st_d;
      pos_q    <= pos_d;
      n_q      <= n_d;
      pend_v_q <= pend_v_d;
      if (a_free) begin
        a_v_q <= push;
      end
      if (out_free) begin
        o_v_q <= a_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_a_q <= pend_a_d;
    pend_b_q <= pend_b_d;
    pend_f_q <= pend_f_d;
    if (load) begin
      cur_q  <= q_job_i.cur;
      prev_q <= q_job_i.prev;
      last_q <= q_job_i.last;
      step_q <= q_job_i.step;
    end
  end

  // (b - a) * frac, registered before the rounding add
  assign diff   = {pend_b_q[SW-1], pend_b_q} - {pend_a_q[SW-1], pend_a_q};
  assign frac_s = $signed({1'b0, pend_f_q});
  assign prod   = diff * frac_s;

  always_ff @(posedge clk_i) begin
    if (a_free && push) begin
      a_base_q <= pend_a_q;
      a_prod_q <= prod;
      a_run_q  <= push_run;
      a_end_q  <= push_end;
    end
  end

  // a * ONE + product + ONE/2, floor shift
  assign sum = (lir_pkg::SUM_W'(a_base_q) <<< FB) + a_prod_q + HALF;

  always_ff @(posedge clk_i) begin
    if (out_free && a_v_q) begin
      o_data_q.sample_out <= sum[FB+SW-1:FB];
      o_data_q.run_end    <= a_run_q;
      o_data_q.stream_end <= a_end_q;
    end
  end

  assign out_valid_o = o_v_q;
  assign out_data_o  = o_data_q;

endmodule
`default_nettype wire

FILE: hdl/lir_checker.sv
// Port-level checker for the resampler, bound to the top level.
`default_nettype none
`include "linear_interp_resampler_defines.svh"
module lir_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        cfg_we_i,
  input wire logic [lir_pkg::STEP_W-1:0]  cfg_wdata_i,
  input wire logic                        in_valid_i,
  input wire logic                        in_stall_o,
  input wire lir_pkg::lir_in_t            in_data_i,
  input wire logic                        out_valid_o,
  input wire logic                        out_stall_i,
  input wire lir_pkg::lir_out_t           out_data_o
);

  logic seen_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        seen_in_q <= 1'b1;
      end
    end
  end

  `LIR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")
  `LIR_ASSERT_NOW(a_end_is_run, clk_i, rst_ni, out_valid_o && out_data_o.stream_end, out_data_o.run_end, "stream_end without run_end")
  `LIR_ASSERT_NOW(a_no_spurious, clk_i, rst_ni, out_valid_o, seen_in_q, "result before any input transfer")
  `LIR_ASSERT_NOW(a_stall_rise, clk_i, rst_ni, $rose(in_stall_o), $past(in_valid_i && !in_stall_o), "input stall rose without a transfer")

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_wdata_i (cfg_wdata_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
`default_nettype wire

FILE: dv/testbench.sv
// Self-checking testbench for the linear interpolation resampler.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Scale of one input period in the phase domain, kept signed for the blend sums.
  localparam longint UNIT = longint'(1) << lir_pkg::FRAC_BITS;
  // Marks a stimulus row whose results come from the predictor, not the table.
  localparam int USE_PREDICTOR = -1;
  // Idle cycles allowed after the last result before the step register is touched:
  // two queued inputs with no output still occupy the sequencer.
  localparam int SETTLE_CYCLES = 12;
  localparam int TAIL_CYCLES = 20;
  localparam int RANDOM_ITEMS = 245;
  // Worst case: 32 results per item, each stalled, plus drains per phase; taken many times over.
  localparam int LIMIT_CYCLES = 400000;

  typedef enum logic {ROW_STEP, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    int                value;    // step for ROW_STEP, sample for ROW_SAMPLE
    logic              last;
    int                pin_n;    // number of typed-in results, or USE_PREDICTOR
    lir_pkg::lir_out_t pin;
  } row_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_we_i;
  logic [lir_pkg::STEP_W-1:0]  cfg_wdata_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  lir_pkg::lir_in_t            in_data_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  lir_pkg::lir_out_t           out_data_o;

  // Predictor state, mirroring the block after reset.
  logic signed [lir_pkg::SAMPLE_W-1:0] held_smp = '0;
  logic                                held_valid = 1'b0;
  logic [lir_pkg::ACC_W-1:0]           phase = '0;
  logic [lir_pkg::STEP_W-1:0]          step_reg = lir_pkg::STEP_W'(lir_pkg::ONE_POS);

  lir_pkg::lir_out_t produced[$];      // results of the most recent prediction
  lir_pkg::lir_out_t pending_outs[$];  // results still owed by the block, oldest first
  row_t              plan[$];

  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 7;
  int stall_pct = 7;

  linear_interp_resampler dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Rounded-half-up blend of a towards b at fraction frac of one period. The bias of
  // 32768 periods keeps the sum non-negative so the shift is a plain floor.
  function automatic logic signed [lir_pkg::SAMPLE_W-1:0] blend(
      logic signed [lir_pkg::SAMPLE_W-1:0] a,
      logic signed [lir_pkg::SAMPLE_W-1:0] b,
      longint frac);
    longint acc;
    acc = longint'(a) * UNIT + (longint'(b) - longint'(a)) * frac + UNIT / 2
        + longint'(32768) * UNIT;
    return lir_pkg::SAMPLE_W'((acc >>> lir_pkg::FRAC_BITS) - 32768);
  endfunction

  // Works out the results of one input sample and advances the predictor state.
  function automatic void resample(lir_pkg::lir_in_t item);
    longint            st;
    longint            pos;
    lir_pkg::lir_out_t r;
    st = (step_reg < lir_pkg::STEP_MIN) ? longint'(lir_pkg::STEP_MIN) : longint'(step_reg);
    pos = longint'(phase);
    produced.delete();
    r = '0;
    if (held_valid) begin
      // outputs falling inside the interval closed by this sample
      while (pos < UNIT && produced.size() < lir_pkg::MAX_OUT) begin
        r.sample_out = blend(held_smp, item.sample_in, pos);
        produced.push_back(r);
        pos += st;
      end
      pos = (pos >= UNIT) ? pos - UNIT : 0;
    end
    if (item.stream_last) begin
      // hold the final sample while the next position stays within one period
      while (pos + st <= UNIT && produced.size() < lir_pkg::MAX_OUT) begin
        r.sample_out = item.sample_in;
        produced.push_back(r);
        pos += st;
      end
      if (produced.size() > 0) produced[produced.size()-1].stream_end = 1'b1;
      held_smp = '0;
      held_valid = 1'b0;
      phase = '0;
    end else begin
      held_smp = item.sample_in;
      held_valid = 1'b1;
      phase = lir_pkg::ACC_W'(pos);
    end
    if (produced.size() > 0) produced[produced.size()-1].run_end = 1'b1;
  endfunction

  function automatic void tab(row_kind_e kind, int value, logic last = 1'b0,
                              int pin_n = USE_PREDICTOR, int pin_smp = 0,
                              logic pin_run = 1'b0, logic pin_stream = 1'b0);
    row_t r;
    r.kind = kind;
    r.value = value;
    r.last = last;
    r.pin_n = pin_n;
    r.pin.sample_out = lir_pkg::SAMPLE_W'(pin_smp);
    r.pin.run_end = pin_run;
    r.pin.stream_end = pin_stream;
    plan.push_back(r);
  endfunction

  // Presents one sample until its transfer completes; called and left just after a
  // falling edge. Valid stays high between back-to-back samples.
  task automatic send_sample(lir_pkg::lir_in_t item, int pin_n, lir_pkg::lir_out_t pin);
    resample(item);
    if (pin_n == USE_PREDICTOR) begin
      foreach (produced[i]) pending_outs.push_back(produced[i]);
    end else if (pin_n == 1) begin
      pending_outs.push_back(pin);
    end
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_data_i = item;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  // Drains the block, then writes the step register.
  task automatic write_step(logic [lir_pkg::STEP_W-1:0] value);
    in_valid_i = 1'b0;
    while (pending_outs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = value;
    @(posedge clk_i);
    step_reg = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // Output stall, changed on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(99) < stall_pct);
  end

  // Result checker: every completed output transfer is matched against the oldest
  // expectation, field by field.
  always @(posedge clk_i) begin
    lir_pkg::lir_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_outs.size() == 0) begin
        $error("result with nothing expected: sample_out %0d run_end %0b stream_end %0b",
               $signed(out_data_o.sample_out), out_data_o.run_end, out_data_o.stream_end);
        mismatches++;
      end else begin
        want = pending_outs.pop_front();
        if (out_data_o.sample_out !== want.sample_out) begin
          $error("sample_out: expected %0d, got %0d",
                 $signed(want.sample_out), $signed(out_data_o.sample_out));
          mismatches++;
        end
        if (out_data_o.run_end !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, out_data_o.run_end);
          mismatches++;
        end
        if (out_data_o.stream_end !== want.stream_end) begin
          $error("stream_end: expected %0b, got %0b", want.stream_end, out_data_o.stream_end);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    lir_pkg::lir_in_t           item;
    logic [lir_pkg::STEP_W-1:0] step;
    int                         sent;
    int                         len;
    int                         pick;
    bit                         closes;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_stall_i = 1'b0;

    // Directed rows; results typed in only where obvious.
    // Reset step is one: first sample of a stream is stored silently.
    tab(ROW_SAMPLE, 32767, 1'b0, 0);
    tab(ROW_SAMPLE, -32768, 1'b0, 1, 32767, 1'b1, 1'b0);
    tab(ROW_SAMPLE, 0, 1'b1);
    // single-sample stream: one held output carrying both end flags
    tab(ROW_SAMPLE, 12345, 1'b1, 1, 12345, 1'b1, 1'b1);
    // half step: two outputs per input, mid-point blends
    tab(ROW_STEP, 32768);
    tab(ROW_SAMPLE, 1000, 1'b0, 0);
    tab(ROW_SAMPLE, 2000);
    tab(ROW_SAMPLE, -1, 1'b1);
    // zero step is clamped to a sixteenth: full-scale swing, then 32 results at the end
    tab(ROW_STEP, 0);
    tab(ROW_SAMPLE, -32768, 1'b0, 0);
    tab(ROW_SAMPLE, 32767, 1'b1);
    // largest step: one output, then a stream end that gives no result at all
    tab(ROW_STEP, 16777215);
    tab(ROW_SAMPLE, 5, 1'b0, 0);
    tab(ROW_SAMPLE, 6, 1'b0, 1, 5, 1'b1, 1'b0);
    tab(ROW_SAMPLE, 7, 1'b1, 0);
    // step above one: end-of-stream count test only on the final interval
    tab(ROW_STEP, 98304);
    tab(ROW_SAMPLE, 10, 1'b0, 0);
    tab(ROW_SAMPLE, 20);
    tab(ROW_SAMPLE, -30000);
    tab(ROW_SAMPLE, 40, 1'b1);
    // smallest legal step, then a sub-minimum step written mid-stream
    tab(ROW_STEP, 4096);
    tab(ROW_SAMPLE, 1, 1'b0, 0);
    tab(ROW_SAMPLE, 2);
    tab(ROW_STEP, 200);
    tab(ROW_SAMPLE, 3, 1'b1);
    tab(ROW_STEP, 65536);
    tab(ROW_SAMPLE, -32768, 1'b1, 1, -32768, 1'b1, 1'b1);
    tab(ROW_SAMPLE, 32767, 1'b1, 1, 32767, 1'b1, 1'b1);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_STEP) begin
        write_step(lir_pkg::STEP_W'(plan[i].value));
      end else begin
        item.sample_in = lir_pkg::SAMPLE_W'(plan[i].value);
        item.stream_last = plan[i].last;
        send_sample(item, plan[i].pin_n, plan[i].pin);
      end
    end

    // Random phases: a step setting, then a mostly well-formed stream of random
    // content. Some phases stop short of the last flag so that the next step write
    // lands mid-stream; a few stray last flags break streams early.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(99);
      if (pick < 4) step = '0;
      else if (pick < 8) step = '1;
      else if (pick < 12) step = lir_pkg::STEP_MIN;
      else if (pick < 16)
        step = lir_pkg::STEP_W'($urandom_range(1, lir_pkg::MIN_STEP - 1));
      else if (pick < 22)
        step = lir_pkg::STEP_W'($urandom_range(lir_pkg::ONE_POS + 1, 16777214));
      else if (pick < 40) step = lir_pkg::STEP_ONE;
      else step = lir_pkg::STEP_W'($urandom_range(lir_pkg::ONE_POS / 4,
                                                  3 * lir_pkg::ONE_POS));
      write_step(step);
      len = $urandom_range(1, 12);
      closes = ($urandom_range(99) < 85);
      for (int k = 0; k < len; k++) begin
        // a stretch with no idling or stalling on either side
        if (sent == 100) begin
          idle_pct = 0;
          stall_pct = 0;
        end else if (sent == 170) begin
          idle_pct = 7;
          stall_pct = 7;
        end
        case ($urandom_range(19))
          0: item.sample_in = 16'sh8000;
          1: item.sample_in = 16'sh7FFF;
          2: item.sample_in = '0;
          3: item.sample_in = '1;
          default: item.sample_in = lir_pkg::SAMPLE_W'($urandom);
        endcase
        item.stream_last = (closes && k == len - 1) || ($urandom_range(99) < 3);
        send_sample(item, USE_PREDICTOR, '0);
        sent++;
      end
    end

    in_valid_i = 1'b0;
    while (pending_outs.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) $display("testbench passed");
    else $display("testbench failed");
    $finish;
  end

endmodule
